@@ design/lz77d_pkg.sv @@
// Package for the LZ77 text token decoder: widths, codes, command type.
// No dependencies.
`default_nettype none
package lz77d_pkg;
  localparam int WINDOW_DEF    = 4096;
  localparam int MAX_MATCH_DEF = 63;
  localparam int WS_W          = 13;
  localparam int DIST_W        = 13;
  localparam int LEN_W         = 7;
  localparam logic [DIST_W-1:0] DIST_SAT = 13'd8191;
  localparam logic [LEN_W-1:0]  LEN_SAT  = 7'd127;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_ESC    = 3'd1;
  localparam logic [2:0] ERR_TOKEN  = 3'd2;
  localparam logic [2:0] ERR_DIST   = 3'd3;
  localparam logic [2:0] ERR_LEN    = 3'd4;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_LIT, CMD_COPY, CMD_ERR
  } cmd_op_t;

  // one command from the parser to the executor
  typedef struct packed {
    cmd_op_t           op;
    logic [7:0]        lit;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
    logic [2:0]        err;
    logic              last;     // last command of this input
    logic              restart;  // restart state after this command
  } cmd_t;
endpackage
`default_nettype wire

@@ design/lz77d_if.sv @@
// Valid/ready channel interfaces for the decoder.
// No dependencies.
`default_nettype none
interface lz77d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, in_byte, stream_end, input ready);
  modport sink (input valid, in_byte, stream_end, output ready);
endinterface

interface lz77d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic [2:0] error_code;
  modport source (output valid, out_byte, run_last, error_code, input ready);
  modport sink (input valid, out_byte, run_last, error_code, output ready);
endinterface

interface lz77d_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ design/lz77_text_token_decoder.sv @@
// LZ77 text token decoder. A literal passes the parser's command slot, the command queue
// and the executor's output register. The parser takes an input, then issues its commands
// (up to two) before it takes the next input; a 4-deep queue decouples it from the executor,
// which takes a literal or error directly and runs a copy of L bytes as a RAM read, then
// a write/emit, per byte. Synchronous reset clears all control state and window_size to
// 4096; history RAM is not cleared.
`default_nettype none
module lz77_text_token_decoder
  import lz77d_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_MATCH = MAX_MATCH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  lz77d_in_if.sink   in_ch,
  lz77d_out_if.source out_ch,
  lz77d_cfg_if.sink  cfg
);
  logic [WS_W-1:0] window_size;
  logic p_valid, p_ready, e_valid, e_ready;
  cmd_t p_cmd, e_cmd;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 13'd4096;
    end else if (cfg.valid) begin
      window_size <= cfg.data;
    end
  end

  lz77d_parser u_parser (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.in_byte), .stream_end(in_ch.stream_end),
    .cmd_valid(p_valid), .cmd_ready(p_ready), .cmd(p_cmd)
  );

  lz77d_queue u_queue (
    .clk, .rst, .in_valid(p_valid), .in_ready(p_ready), .in_cmd(p_cmd),
    .out_valid(e_valid), .out_ready(e_ready), .out_cmd(e_cmd)
  );

  lz77d_exec #(.WINDOW(WINDOW), .MAX_MATCH(MAX_MATCH)) u_exec (
    .clk, .rst, .window_size, .cmd_valid(e_valid), .cmd_ready(e_ready), .cmd(e_cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_byte(out_ch.out_byte),
    .run_last(out_ch.run_last), .error_code(out_ch.error_code)
  );
endmodule
`default_nettype wire

@@ design/lz77d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lz77d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ design/lz77d_parser.sv @@
// Front end: parses compressed bytes into literal, copy, error and NOP flush commands.
// Depends on lz77d_pkg.
`default_nettype none
module lz77d_parser
  import lz77d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       stream_end,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);
  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_DIST, PH_COMMA, PH_LEN
  } phase_t;

  // at most two commands per input: a copy followed by a literal or an error, or a NOP flush when there is none
  localparam int NSLOT = 3;

  phase_t            phase;
  logic [DIST_W-1:0] dacc;
  logic [LEN_W-1:0]  lacc;
  logic              err_seen;
  cmd_t              slot [NSLOT];
  logic [1:0]        nslot;
  logic [1:0]        sidx;
  logic              busy;

  phase_t            ph_n;
  logic [DIST_W-1:0] d_n;
  logic [LEN_W-1:0]  l_n;
  logic              es_n;
  cmd_t              s_n [NSLOT];
  logic [1:0]        n_n;
  logic              digit;
  logic [3:0]        dv;
  logic [DIST_W+3:0] dmul;
  logic [LEN_W+3:0]  lmul;
  logic              stop;

  assign in_ready  = !busy;
  assign cmd_valid = busy;
  assign cmd       = slot[sidx];
  assign digit     = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign dv        = 4'(in_byte - CH_ZERO);
  assign dmul      = {4'd0, dacc} * 17'd10 + {13'd0, dv};
  assign lmul      = {4'd0, lacc} * 11'd10 + {7'd0, dv};

  function automatic cmd_t mk(cmd_op_t op, logic [7:0] b, logic [DIST_W-1:0] d,
                              logic [LEN_W-1:0] l, logic [2:0] e);
    cmd_t c;
    c.op = op; c.lit = b; c.distance = d; c.len = l; c.err = e;
    c.last = 1'b0; c.restart = 1'b0;
    return c;
  endfunction

  always_comb begin
    ph_n = phase; d_n = dacc; l_n = lacc; es_n = err_seen;
    n_n = 2'd0; stop = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      s_n[i] = mk(CMD_NOP, 8'd0, '0, '0, ERR_NONE);
    end
    if (!err_seen) begin
      case (phase)
        PH_ESC: begin
          if (in_byte == CH_PCT) begin
            ph_n = PH_IDLE; s_n[0] = mk(CMD_LIT, in_byte, '0, '0, ERR_NONE); n_n = 2'd1;
          end else if (digit) begin
            d_n = {9'd0, dv}; ph_n = PH_DIST;
          end else begin
            s_n[0] = mk(CMD_ERR, 8'd0, '0, '0, ERR_TOKEN); n_n = 2'd1;
            es_n = 1'b1; ph_n = PH_IDLE;
          end
        end
        PH_DIST: begin
          if (digit) begin
            d_n = (dmul > {4'd0, DIST_SAT}) ? DIST_SAT : dmul[DIST_W-1:0];
          end else if (in_byte == CH_COMMA) begin
            ph_n = PH_COMMA;
          end else begin
            s_n[0] = mk(CMD_ERR, 8'd0, '0, '0, ERR_TOKEN); n_n = 2'd1;
            es_n = 1'b1; ph_n = PH_IDLE;
          end
        end
        PH_COMMA: begin
          if (digit) begin
            l_n = {3'd0, dv}; ph_n = PH_LEN;
          end else begin
            s_n[0] = mk(CMD_ERR, 8'd0, '0, '0, ERR_TOKEN); n_n = 2'd1;
            es_n = 1'b1; ph_n = PH_IDLE;
          end
        end
        PH_LEN: begin
          if (digit) begin
            l_n = (lmul > {4'd0, LEN_SAT}) ? LEN_SAT : lmul[LEN_W-1:0];
          end else begin
            // the copy is checked in the back end; a failure there drops what follows
            s_n[0] = mk(CMD_COPY, 8'd0, dacc, lacc, ERR_NONE);
            ph_n = PH_IDLE;
            if (in_byte == CH_PCT) begin
              ph_n = PH_ESC; n_n = 2'd1;
            end else begin
              s_n[1] = mk(CMD_LIT, in_byte, '0, '0, ERR_NONE); n_n = 2'd2;
            end
          end
        end
        default: begin
          ph_n = PH_IDLE;
          if (in_byte == CH_PCT) begin
            ph_n = PH_ESC;
          end else begin
            s_n[0] = mk(CMD_LIT, in_byte, '0, '0, ERR_NONE); n_n = 2'd1;
          end
        end
      endcase
    end
    if (stream_end) begin
      if (!es_n) begin
        case (ph_n)
          PH_ESC: begin
            s_n[n_n] = mk(CMD_ERR, 8'd0, '0, '0, ERR_ESC); n_n = n_n + 2'd1;
          end
          PH_DIST, PH_COMMA: begin
            s_n[n_n] = mk(CMD_ERR, 8'd0, '0, '0, ERR_TOKEN); n_n = n_n + 2'd1;
          end
          PH_LEN: begin
            s_n[n_n] = mk(CMD_COPY, 8'd0, d_n, l_n, ERR_NONE); n_n = n_n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      if (n_n == 2'd0) begin
        s_n[0] = mk(CMD_NOP, 8'd0, '0, '0, ERR_NONE); n_n = 2'd1;
      end
      ph_n = PH_IDLE; d_n = '0; l_n = '0; es_n = 1'b0; stop = 1'b1;
    end
    if (n_n != 2'd0) begin
      s_n[n_n-2'd1].last = 1'b1;
      s_n[n_n-2'd1].restart = stop;
    end
    if (es_n && !err_seen) begin
      d_n = '0; l_n = '0;
    end
    if (phase == PH_LEN && !digit && !err_seen) begin
      d_n = '0; l_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; dacc <= '0; lacc <= '0; err_seen <= 1'b0;
      busy <= 1'b0; nslot <= 2'd0; sidx <= 2'd0;
    end else if (!busy) begin
      if (in_valid) begin
        phase <= ph_n; dacc <= d_n; lacc <= l_n; err_seen <= es_n;
        for (int i = 0; i < NSLOT; i++) begin
          slot[i] <= s_n[i];
        end
        nslot <= n_n; sidx <= 2'd0;
        busy <= (n_n != 2'd0);
      end
    end else if (cmd_ready) begin
      if (sidx + 2'd1 == nslot) begin
        busy <= 1'b0;
      end else begin
        sidx <= sidx + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/lz77d_queue.sv @@
// Short command queue between parser and executor.
// Depends on lz77d_pkg.
`default_nettype none
module lz77d_queue
  import lz77d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      out_cmd
);
  localparam int DEPTH = 4;
  cmd_t       q [DEPTH];
  logic [1:0] rp, wp;
  logic [2:0] cnt;
  logic       push, pop;

  assign in_ready  = (cnt != 3'(DEPTH));
  assign out_valid = (cnt != 3'd0);
  assign out_cmd   = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0; wp <= '0; cnt <= '0;
    end else begin
      if (push) begin
        q[wp] <= in_cmd; wp <= wp + 2'd1;
      end
      if (pop) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

@@ design/lz77d_exec.sv @@
// Back end: checks copies, runs them through the history RAM, emits results.
// Depends on lz77d_pkg and lz77d_ram.
`default_nettype none
module lz77d_exec
  import lz77d_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_MATCH = MAX_MATCH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [WS_W-1:0] window_size,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire cmd_t            cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic [2:0]           error_code
);
  localparam int AW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    ST_TAKE, ST_READ, ST_COPY, ST_DROP
  } state_t;

  state_t            state;
  logic [AW-1:0]     wptr, src;
  logic [FW-1:0]     filled;
  logic [LEN_W-1:0]  left;
  cmd_t              cur;
  logic              pend;   // read data of src is valid while set

  logic              we, re;
  logic [AW-1:0]     raddr;
  logic [7:0]        wdata, rdata;
  logic              fwd_ok;
  logic [7:0]        fwd;
  logic [FW-1:0]     lim;
  logic              dist_bad, len_bad;

  lz77d_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_hist (
    .clk, .we, .waddr(wptr), .wdata, .re, .raddr, .rdata
  );

  assign lim = (32'(window_size) >= WINDOW) ? FW'(WINDOW) : FW'(window_size);
  assign dist_bad = (cmd.distance == '0) || (32'(cmd.distance) > 32'(filled))
    || (32'(cmd.distance) > 32'(lim));
  assign len_bad = (cmd.len == '0) || (32'(cmd.len) > MAX_MATCH)
    || (cmd.len > cmd.distance[LEN_W-1:0] && cmd.distance < DIST_W'(128))
    || 1'b0;

  // output register is free when empty or being taken
  assign fwd_ok = !out_valid || out_ready;
  assign fwd    = pend ? rdata : 8'd0;
  assign cmd_ready = (state == ST_TAKE || state == ST_DROP) && fwd_ok;
  assign we     = ((state == ST_TAKE) && cmd_valid && fwd_ok && cmd.op == CMD_LIT)
               || ((state == ST_COPY) && fwd_ok && pend);
  assign wdata  = (state == ST_COPY) ? rdata : cmd.lit;
  assign re     = 1'b1;
  assign raddr  = (state == ST_COPY && fwd_ok && pend) ?
                  ((32'(src) + 1 >= WINDOW) ? '0 : src + AW'(1)) : src;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE; wptr <= '0; filled <= '0; out_valid <= 1'b0;
      pend <= 1'b0; left <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_TAKE, ST_DROP: begin
          if (cmd_valid && fwd_ok) begin
            cur <= cmd;
            if (state == ST_DROP || cmd.op == CMD_NOP) begin
              if (cmd.last && state == ST_TAKE && cmd.op == CMD_NOP) begin
                out_valid <= 1'b0;
              end
              if (cmd.restart) begin
                state <= ST_TAKE; wptr <= '0; filled <= '0;
              end
            end else if (cmd.op == CMD_LIT) begin
              out_valid <= 1'b1; out_byte <= cmd.lit; error_code <= ERR_NONE;
              run_last <= cmd.last;
              wptr <= (32'(wptr) + 1 >= WINDOW) ? '0 : wptr + AW'(1);
              if (32'(filled) < WINDOW) filled <= filled + FW'(1);
              if (cmd.restart) begin
                wptr <= '0; filled <= '0;
              end
            end else if (cmd.op == CMD_ERR ||
                         (cmd.op == CMD_COPY && (dist_bad || len_bad))) begin
              out_valid <= 1'b1; out_byte <= 8'd0; run_last <= 1'b1;
              error_code <= (cmd.op == CMD_ERR) ? cmd.err :
                            (dist_bad ? ERR_DIST : ERR_LEN);
              if (cmd.restart) begin
                wptr <= '0; filled <= '0;
              end else begin
                state <= ST_DROP;
              end
            end else begin
              src  <= (32'(wptr) >= 32'(cmd.distance)) ?
                      AW'(32'(wptr) - 32'(cmd.distance)) :
                      AW'(32'(wptr) + WINDOW - 32'(cmd.distance));
              left <= cmd.len;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          pend <= 1'b1; state <= ST_COPY;
        end
        ST_COPY: begin
          if (fwd_ok && pend) begin
            out_valid <= 1'b1; out_byte <= fwd; error_code <= ERR_NONE;
            run_last <= cur.last && (left == LEN_W'(1));
            wptr <= (32'(wptr) + 1 >= WINDOW) ? '0 : wptr + AW'(1);
            if (32'(filled) < WINDOW) filled <= filled + FW'(1);
            src <= raddr;
            // length never exceeds distance, so the next source byte is already stored
            pend <= 1'b0;
            if (left == LEN_W'(1)) begin
              state <= ST_TAKE;
              if (cur.restart) begin
                wptr <= '0; filled <= '0;
              end
            end else begin
              left <= left - LEN_W'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_TAKE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ dv/lz77d_checker.sv @@
// Checker for the LZ77 text token decoder: watches input, output and config
// transactions, predicts the decompressed stream and compares it. Uses lz77d_pkg.
`timescale 1ns / 1ps
module lz77d_checker
  import lz77d_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [7:0] in_byte,
  input wire logic in_end,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [7:0] out_byte,
  input wire logic out_last,
  input wire logic [2:0] out_err,
  input wire logic cfg_valid,
  input wire logic cfg_ready,
  input wire logic [12:0] cfg_data,
  output int fail_count,
  output int pending
);
  typedef enum logic [2:0] {PH_IDLE, PH_ESC, PH_DIST, PH_COMMA, PH_LEN} phase_t;
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic [2:0] err;
  } out_item_t;

  logic [7:0]        hist [0:WINDOW_DEF-1];
  logic [11:0]       wp;
  logic [12:0]       filled;
  phase_t            ph;
  logic [DIST_W-1:0] dacc;
  logic [LEN_W-1:0]  lacc;
  logic              err_seen;
  logic [12:0]       win;
  out_item_t         exp_bytes[$];
  out_item_t         step_q[$];

  assign pending = exp_bytes.size();

  function automatic logic [13:0] sat_mul(logic [13:0] acc, logic [3:0] d, logic [13:0] sat);
    logic [17:0] v;
    v = 18'(acc) * 18'd10 + 18'(d);
    return (acc > sat || v > 18'(sat)) ? sat : v[13:0];
  endfunction

  function automatic void emit(logic [7:0] b, logic [2:0] e);
    out_item_t it;
    it.b = b; it.last = 1'b0; it.err = e;
    step_q.push_back(it);
  endfunction

  function automatic void store(logic [7:0] b);
    hist[wp] = b;
    wp = wp + 12'd1;
    if (filled < 13'(WINDOW_DEF)) filled = filled + 13'd1;
    emit(b, ERR_NONE);
  endfunction

  function automatic void abort(logic [2:0] e);
    emit(8'h00, e);
    err_seen = 1'b1;
    ph = PH_IDLE; dacc = '0; lacc = '0;
  endfunction

  function automatic void begin_item(logic [7:0] b);
    if (b == CH_PCT) ph = PH_ESC;
    else store(b);
  endfunction

  function automatic bit do_copy();
    logic [12:0] d, lim;
    logic [6:0]  l;
    logic [11:0] src;
    d = dacc; l = lacc;
    lim = (win < 13'(WINDOW_DEF)) ? win : 13'(WINDOW_DEF);
    ph = PH_IDLE; dacc = '0; lacc = '0;
    if (d == 0 || d > filled || d > lim) begin
      abort(ERR_DIST);
      return 1'b0;
    end
    if (l == 0 || l > MAX_MATCH_DEF || l > d) begin
      abort(ERR_LEN);
      return 1'b0;
    end
    src = wp - d[11:0];
    for (int i = 0; i < l; i++) begin
      store(hist[src]);
      src = src + 12'd1;
    end
    return 1'b1;
  endfunction

  task automatic predict(logic [7:0] b, logic e);
    bit dig;
    dig = (b >= CH_ZERO && b <= CH_NINE);
    step_q.delete();
    if (!err_seen) begin
      case (ph)
        PH_ESC: begin
          if (b == CH_PCT) begin
            ph = PH_IDLE; store(b);
          end else if (dig) begin
            dacc = 13'(b - CH_ZERO); ph = PH_DIST;
          end else abort(ERR_TOKEN);
        end
        PH_DIST: begin
          if (dig) dacc = 13'(sat_mul(14'(dacc), 4'(b - CH_ZERO), 14'(DIST_SAT)));
          else if (b == CH_COMMA) ph = PH_COMMA;
          else abort(ERR_TOKEN);
        end
        PH_COMMA: begin
          if (dig) begin
            lacc = 7'(b - CH_ZERO); ph = PH_LEN;
          end else abort(ERR_TOKEN);
        end
        PH_LEN: begin
          if (dig) lacc = 7'(sat_mul(14'(lacc), 4'(b - CH_ZERO), 14'(LEN_SAT)));
          else if (do_copy()) begin_item(b);
        end
        default: begin
          ph = PH_IDLE; begin_item(b);
        end
      endcase
    end
    if (e) begin
      if (!err_seen) begin
        if (ph == PH_ESC) abort(ERR_ESC);
        else if (ph == PH_DIST || ph == PH_COMMA) abort(ERR_TOKEN);
        else if (ph == PH_LEN) void'(do_copy());
      end
      wp = '0; filled = '0; ph = PH_IDLE; dacc = '0; lacc = '0; err_seen = 1'b0;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) exp_bytes.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      wp = '0; filled = '0; ph = PH_IDLE; dacc = '0; lacc = '0;
      err_seen = 1'b0; win = 13'd4096; fail_count = 0;
      exp_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) win = cfg_data;
      if (in_valid && in_ready) predict(in_byte, in_end);
      if (out_valid && out_ready) begin
        if (exp_bytes.size() == 0) begin
          $error("unexpected transaction: out_byte %0h", out_byte);
          fail_count++;
        end else begin
          want = exp_bytes.pop_front();
          if (want.b !== out_byte) begin
            $error("out_byte exp %0h got %0h", want.b, out_byte); fail_count++;
          end
          if (want.last !== out_last) begin
            $error("run_last exp %0d got %0d", want.last, out_last); fail_count++;
          end
          if (want.err !== out_err) begin
            $error("error_code exp %0d got %0d", want.err, out_err); fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ dv/tb_lz77_text_token_decoder.sv @@
// Testbench top for the LZ77 text token decoder: drives byte streams and
// window settings, stalls the output, and reports the verdict. Uses lz77d_checker.
`timescale 1ns / 1ps
module tb_lz77_text_token_decoder;
  import lz77d_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending, idle_cycles;
  bit   hold_off = 1'b0;
  logic [8:0] tok_q[$];

  lz77d_in_if  in_ch();
  lz77d_out_if out_ch();
  lz77d_cfg_if cfg();

  lz77_text_token_decoder dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

  lz77d_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.in_byte), .in_end(in_ch.stream_end),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_byte(out_ch.out_byte), .out_last(out_ch.run_last), .out_err(out_ch.error_code),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_data(cfg.data),
    .fail_count(fails), .pending(pending));

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.in_byte = '0; in_ch.stream_end = 1'b0;
    out_ch.ready = 1'b0; cfg.valid = 1'b0; cfg.data = '0;
  end

  // receiver stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_ch.ready <= 1'b0;
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_txt(string s, bit fin);
    for (int i = 0; i < s.len(); i++) tok_q.push_back({fin && i == s.len()-1, s[i]});
  endtask

  task automatic send_all();
    int burst;
    while (tok_q.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && tok_q.size() > 0) begin
        {in_ch.stream_end, in_ch.in_byte} <= tok_q.pop_front();
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        in_ch.stream_end <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    in_ch.stream_end <= 1'b0;
  endtask

  task automatic drain();
    while (pending > 0) @(negedge clk);
    repeat (140) @(negedge clk);
  endtask

  task automatic set_window(logic [12:0] w);
    cfg.data <= w; cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic string num(int v);
    return $sformatf("%0d", v);
  endfunction

  task automatic rand_stream(int n_items);
    int filled, d, l, k;
    filled = 0;
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(0, 19);
      if (k < 9 || filled == 0) begin
        logic [7:0] c;
        c = $urandom_range(0, 255);
        if (c == CH_PCT) c = 8'h41;
        tok_q.push_back({1'b0, c}); filled++;
      end else if (k < 15) begin
        d = $urandom_range(1, filled < 70 ? filled : 70);
        l = $urandom_range(1, d < 12 ? d : 12);
        if ($urandom_range(0, 9) == 0) l = $urandom_range(1, d < 63 ? d : 63);
        push_txt({"%", num(d), ",", num(l)}, 1'b0); filled += l;
      end else if (k == 15) begin
        push_txt("%%", 1'b0); filled++;
      end else if (k == 16) begin
        push_txt({"%", num($urandom_range(0, 9999)), ",", num($urandom_range(0, 200))}, 1'b0);
        if ($urandom_range(0, 1)) tok_q.push_back({1'b0, 8'h78});
      end else begin
        tok_q.push_back({1'b0, 8'(CH_PCT)});
        tok_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        if ($urandom_range(0, 1)) tok_q.push_back({1'b0, 8'(CH_COMMA)});
      end
    end
    tok_q[tok_q.size()-1][8] = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed
    push_txt("ab%%%1,1%2,2", 1'b0);
    tok_q.push_back({1'b0, 8'hff}); tok_q.push_back({1'b0, 8'h00});
    push_txt("%6,0x", 1'b1);
    push_txt("ab%3,1", 1'b1);
    push_txt("abc%3,4z", 1'b1);
    push_txt("%q", 1'b1);
    push_txt("%", 1'b1);
    push_txt("%12", 1'b1);
    push_txt("%1,", 1'b1);
    push_txt("%1x", 1'b1);
    push_txt("a%99999999,1", 1'b1);
    push_txt("a%1,99999", 1'b1);
    push_txt("a%1,1", 1'b1);
    send_all(); drain();
    set_window(13'd0);
    push_txt("ab%1,1", 1'b1);
    send_all(); drain();
    set_window(13'd1);
    push_txt("ab%1,1%2,1", 1'b1);
    send_all(); drain();
    set_window(13'd8191);
    // long hold-off while input keeps flowing
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        push_txt("abcdefgh%8,8%16,16", 1'b0); rand_stream(20);
        send_all();
      end
    join
    drain();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_window(13'd4096);
        1: set_window(13'd20);
        2: set_window(13'd4095);
        default: set_window(13'($urandom_range(1, 8191)));
      endcase
      for (int s = 0; s < 2; s++) rand_stream($urandom_range(10, 20));
      send_all();
      drain();
    end
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
